### sv/mjdtd_pkg.sv
// ----------------------------------------------------------------------------
// mjdtd_pkg: shared types and constants of the MJD date converter
// Field widths, stream packing, divider reciprocals and month tables.
// ----------------------------------------------------------------------------
package mjdtd_pkg;

	// Field widths
	localparam int MJD_W  = 20;
	localparam int LEN_W  = 6;
	localparam int YEAR_W = 13;
	localparam int MON_W  = 4;
	localparam int DAY_W  = 5;
	localparam int DOY_W  = 9;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	// Register stages of one date conversion
	localparam int CONV_STAGES = 8;

	// Day count from the fixed epoch of the four-century step
	localparam int A_W = 22;
	localparam logic [A_W-1:0] JD_OFS = 22'd2468570;

	// floor(4a / 146097): reciprocal 114 / 2^22 underestimates by at most one
	localparam int CENT_W  = 7;
	localparam int CENT_SH = 22;
	localparam logic [CENT_W-1:0] CENT_RECIP = 7'd114;
	localparam logic [17:0] DAYS_400Y = 18'd146097;
	localparam logic [CENT_W-1:0] CENT_BASE = 7'd49;
	localparam int CPR_W = 6;

	// floor(4000 (a + 1) / 1461001): reciprocal 179 / 2^16
	localparam int A2_W  = 16;
	localparam int YQ_W  = 7;
	localparam int YQ_SH = 16;
	localparam int N2_W  = 28;
	localparam logic [7:0] YQ_RECIP = 8'd179;
	localparam logic [11:0] YQ_NUM = 12'd4000;
	localparam logic [20:0] DAYS_4000Y = 21'd1461001;
	localparam logic [YQ_W-1:0] YQ_CENTURY = 7'd100;
	localparam logic [10:0] DAYS_4Y = 11'd1461;
	localparam logic [4:0] MARCH_OFS = 5'd31;

	// floor(80 a / 2447): reciprocal 33 / 2^10
	localparam int A3_W  = 10;
	localparam int MQ_W  = 4;
	localparam int MQ_SH = 10;
	localparam logic [5:0] MQ_RECIP = 6'd33;
	localparam logic [6:0] MQ_NUM = 7'd80;
	localparam logic [11:0] MQ_DEN = 12'd2447;
	localparam logic [MQ_W-1:0] MQ_WRAP = 4'd11;

	// floor(2447 i / 80) for each month index i
	localparam logic [8:0] MQ_DAYS [16] = '{
		9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
	};

	// Days before the first of each month in a common year
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};
	localparam logic [MON_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MON_W-1:0] MONTH_LAST = 4'd11;

	localparam logic [LEN_W-1:0] LEN_INSERT = 6'd61;
	localparam logic [LEN_W-1:0] LEN_DELETE = 6'd59;

	typedef enum logic [1:0] {
		LEAP_NONE   = 2'd0,
		LEAP_INSERT = 2'd1,
		LEAP_DELETE = 2'd2
	} leap_code_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic              leap_year;
	} ymd_t;

	// Request word, last declared field in the lowest bits
	typedef struct packed {
		logic [0:0]       pad;
		logic [LEN_W-1:0] last_minute_len;
		logic [MJD_W-1:0] leap_mjd;
		logic             leap_pending;
		logic [MJD_W-1:0] mjd_day;
	} req_t;

	// Result word, last declared field in the lowest bits
	typedef struct packed {
		logic [6:0]        pad;
		leap_code_t        leap_code;
		logic [DOY_W-1:0]  day_of_year;
		logic [DAY_W-1:0]  cal_day;
		logic [MON_W-1:0]  cal_month;
		logic [YEAR_W-1:0] cal_year;
	} res_t;

	typedef struct packed {
		logic             pending;
		logic [LEN_W-1:0] len;
	} side_t;

endpackage

### sv/mjdtd_ymd.sv
// ----------------------------------------------------------------------------
// mjdtd_ymd: MJD to Gregorian year, month, day
// Eight-stage integer Fliegel-Van Flandern conversion; each stage loads on
// its own enable bit.
// ----------------------------------------------------------------------------
module mjdtd_ymd (
	input  logic                                clk,
	input  logic [mjdtd_pkg::CONV_STAGES-1:0]   en,
	input  logic [mjdtd_pkg::MJD_W-1:0]         mjd,
	output mjdtd_pkg::ymd_t                     ymd
);
	import mjdtd_pkg::*;

	localparam int P1_W = A_W + CENT_W;
	localparam int N1_W = A_W + 2;
	localparam int P3_W = A2_W + 8;
	localparam int T5_W = 18;
	localparam int W5_W = 17;
	localparam int P6_W = 16;
	localparam int R7_W = 17;

	// stage 1: day count and century estimate
	logic [A_W-1:0]    a_c;
	logic [P1_W-1:0]   p1_c;
	logic [A_W-1:0]    a_s1;
	logic [CENT_W-1:0] qe1_s1;

	assign a_c  = A_W'(mjd) + JD_OFS;
	assign p1_c = P1_W'(a_c) * P1_W'(CENT_RECIP);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1   <= a_c;
			qe1_s1 <= p1_c[CENT_SH +: CENT_W];
		end
	end

	// stage 2: correct century, day within the four centuries
	logic [N1_W-1:0]   r0_c, r1_c;
	logic              ge2_c;
	logic [CENT_W-1:0] cent_c;
	logic [A2_W-1:0]   a2_s2;
	logic [CPR_W-1:0]  cpr_s2;

	always_comb begin
		r0_c   = {a_s1, 2'b00} - N1_W'(DAYS_400Y) * N1_W'(qe1_s1);
		ge2_c  = r0_c >= N1_W'(DAYS_400Y);
		r1_c   = ge2_c ? r0_c - N1_W'(DAYS_400Y) : r0_c;
		cent_c = qe1_s1 + CENT_W'(ge2_c) - CENT_BASE;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a2_s2  <= r1_c[2 +: A2_W];
			cpr_s2 <= cent_c[CPR_W-1:0];
		end
	end

	// stage 3: year-in-century estimate
	logic [A2_W-1:0]  m_c;
	logic [P3_W-1:0]  p3_c;
	logic [N2_W-1:0]  n2_s3;
	logic [YQ_W-1:0]  qe2_s3;
	logic [A2_W-1:0]  a2_s3;
	logic [CPR_W-1:0] cpr_s3;

	assign m_c  = a2_s2 + A2_W'(1);
	assign p3_c = P3_W'(m_c) * P3_W'(YQ_RECIP);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			n2_s3  <= N2_W'(m_c) * N2_W'(YQ_NUM);
			qe2_s3 <= p3_c[YQ_SH +: YQ_W];
			a2_s3  <= a2_s2;
			cpr_s3 <= cpr_s2;
		end
	end

	// stage 4: correct year in century
	logic [N2_W-1:0]  r2_c;
	logic             ge4_c;
	logic [YQ_W-1:0]  yq_s4;
	logic [A2_W-1:0]  a2_s4;
	logic [CPR_W-1:0] cpr_s4;

	assign r2_c  = n2_s3 - N2_W'(DAYS_4000Y) * N2_W'(qe2_s3);
	assign ge4_c = r2_c >= N2_W'(DAYS_4000Y);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			yq_s4  <= qe2_s3 + YQ_W'(ge4_c);
			a2_s4  <= a2_s3;
			cpr_s4 <= cpr_s3;
		end
	end

	// stage 5: day counted from the first of March, base year
	logic [T5_W-1:0]   t5_c;
	logic [W5_W-1:0]   a3w_c;
	logic [A3_W-1:0]   a3_s5;
	logic [YEAR_W-1:0] yb_s5;
	logic [CPR_W-1:0]  cpr_s5;
	logic [YQ_W-1:0]   yq_s5;

	assign t5_c  = T5_W'(yq_s4) * T5_W'(DAYS_4Y);
	assign a3w_c = W5_W'(a2_s4) + W5_W'(MARCH_OFS) - W5_W'(t5_c >> 2);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			a3_s5  <= a3w_c[A3_W-1:0];
			yb_s5  <= YEAR_W'(cpr_s4) * YEAR_W'(YQ_CENTURY) + YEAR_W'(yq_s4);
			cpr_s5 <= cpr_s4;
			yq_s5  <= yq_s4;
		end
	end

	// stage 6: month index estimate
	logic [P6_W-1:0]   p6_c;
	logic [MQ_W-1:0]   qe3_s6;
	logic [A3_W-1:0]   a3_s6;
	logic [YEAR_W-1:0] yb_s6;
	logic [CPR_W-1:0]  cpr_s6;
	logic [YQ_W-1:0]   yq_s6;

	assign p6_c = P6_W'(a3_s5) * P6_W'(MQ_RECIP);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			qe3_s6 <= p6_c[MQ_SH +: MQ_W];
			a3_s6  <= a3_s5;
			yb_s6  <= yb_s5;
			cpr_s6 <= cpr_s5;
			yq_s6  <= yq_s5;
		end
	end

	// stage 7: correct month index
	logic [R7_W-1:0]   r3_c;
	logic              ge7_c;
	logic [MQ_W-1:0]   mq_s7;
	logic [A3_W-1:0]   a3_s7;
	logic [YEAR_W-1:0] yb_s7;
	logic [CPR_W-1:0]  cpr_s7;
	logic [YQ_W-1:0]   yq_s7;

	assign r3_c  = R7_W'(a3_s6) * R7_W'(MQ_NUM) - R7_W'(MQ_DEN) * R7_W'(qe3_s6);
	assign ge7_c = r3_c >= R7_W'(MQ_DEN);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			mq_s7  <= qe3_s6 + MQ_W'(ge7_c);
			a3_s7  <= a3_s6;
			yb_s7  <= yb_s6;
			cpr_s7 <= cpr_s6;
			yq_s7  <= yq_s6;
		end
	end

	// stage 8: day, month, year and leap-year flag
	logic             k_c;
	logic [A3_W-1:0]  dy_c;
	logic [YQ_W-1:0]  y2_c;
	logic [CPR_W-1:0] cen_c;
	logic             leap_c;
	ymd_t             ymd_s8;

	always_comb begin
		k_c   = mq_s7 >= MQ_WRAP;
		dy_c  = a3_s7 - A3_W'(MQ_DAYS[mq_s7]);
		y2_c  = yq_s7 + YQ_W'(k_c);
		cen_c = (y2_c == YQ_CENTURY) ? cpr_s7 + CPR_W'(1) : cpr_s7;
		// century years follow the 400-year rule, the rest the 4-year rule
		if (y2_c == YQ_W'(0) || y2_c == YQ_CENTURY) begin
			leap_c = cen_c[1:0] == 2'b00;
		end else begin
			leap_c = y2_c[1:0] == 2'b00;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			ymd_s8.year      <= yb_s7 + YEAR_W'(k_c);
			ymd_s8.month     <= k_c ? mq_s7 - MQ_W'(10) : mq_s7 + MQ_W'(2);
			ymd_s8.day       <= dy_c[DAY_W-1:0];
			ymd_s8.leap_year <= leap_c;
		end
	end

	assign ymd = ymd_s8;

endmodule

### sv/mjd_to_date_leap_classifier_core.sv
// ----------------------------------------------------------------------------
// mjd_to_date_leap_classifier_core: MJD to Gregorian date and leap warning
// Stages: eight conversion stages plus the day-of-year and leap-code stage
//   lie between request accept and result valid.
// Throughput: one request per cycle unless the output stalls, set by the
//   pipelined datapath; stages hold on back-pressure, bubbles squeeze out.
// Reset: arst_n clears all stage valid bits asynchronously; data holds.
// ----------------------------------------------------------------------------
module mjd_to_date_leap_classifier_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// mjd_day[19:0], leap_pending[20], leap_mjd[40:21], last_minute_len[46:41]
	input  logic [mjdtd_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// cal_year[12:0], cal_month[16:13], cal_day[21:17], day_of_year[30:22],
	// leap_code[32:31]
	output logic [mjdtd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import mjdtd_pkg::*;

	localparam int NT = CONV_STAGES + 1;

	req_t             req;
	logic [NT-1:0]    vld_s;
	logic [NT-1:0]    adv;
	side_t            side_s [CONV_STAGES];
	ymd_t             cur_ymd, lp_ymd;
	res_t             res_s9;

	assign req = req_t'(s_tdata);

	// Stage i loads when it is empty or its contents move on downstream.
	always_comb begin
		adv[NT-1] = !vld_s[NT-1] || m_tready;
		for (int i = NT - 2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign s_tready = adv[0];

	// Advance the valid bits alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int i = 1; i < NT; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Carry the leap report beside the two conversions.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			side_s[0].pending <= req.leap_pending;
			side_s[0].len     <= req.last_minute_len;
		end
		for (int i = 1; i < CONV_STAGES; i++) begin
			if (adv[i]) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Convert the current date and the leap date in lockstep.
	mjdtd_ymd u_cur (
		.clk (clk),
		.en  (adv[CONV_STAGES-1:0]),
		.mjd (req.mjd_day),
		.ymd (cur_ymd)
	);

	mjdtd_ymd u_leap (
		.clk (clk),
		.en  (adv[CONV_STAGES-1:0]),
		.mjd (req.leap_mjd),
		.ymd (lp_ymd)
	);

	// Final stage: ordinal day and leap warning into the output register.
	logic [MON_W-1:0] midx_c;
	logic [DOY_W-1:0] doy_c;
	leap_code_t       code_c;
	side_t            side_last;

	assign side_last = side_s[CONV_STAGES-1];

	always_comb begin
		midx_c = cur_ymd.month - MON_W'(1);
		if (midx_c > MONTH_LAST) begin
			midx_c = MONTH_LAST;
		end
		doy_c = DOY_W'(cur_ymd.day) + MONTH_START[midx_c]
			+ DOY_W'(cur_ymd.leap_year && (cur_ymd.month > MONTH_FEB));

		// only year and month are compared, the day of the leap is not
		code_c = LEAP_NONE;
		if (side_last.pending && lp_ymd.month == cur_ymd.month
				&& lp_ymd.year == cur_ymd.year) begin
			priority if (side_last.len == LEN_INSERT) begin
				code_c = LEAP_INSERT;
			end else if (side_last.len == LEN_DELETE) begin
				code_c = LEAP_DELETE;
			end else begin
				code_c = LEAP_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NT-1]) begin
			res_s9.pad         <= '0;
			res_s9.leap_code   <= code_c;
			res_s9.day_of_year <= doy_c;
			res_s9.cal_day     <= cur_ymd.day;
			res_s9.cal_month   <= cur_ymd.month;
			res_s9.cal_year    <= cur_ymd.year;
		end
	end

	assign m_tvalid = vld_s[NT-1];
	assign m_tdata  = res_s9;

	// An empty output stage lets every stage advance, so requests flow in.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request stalled with empty output stage");

	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s[0])
		else $error("accepted request missing from first stage");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s9.cal_month >= MON_W'(1) && res_s9.cal_month <= MON_W'(12)))
		else $error("month out of range");

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s9.day_of_year >= DOY_W'(1)
			&& res_s9.day_of_year <= DOY_W'(366) && res_s9.cal_day != DAY_W'(0)))
		else $error("day or day of year out of range");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the MJD to Gregorian date and leap-warning core
// Streams calendar corner cases and then random requests clustered around
// leap-second matches through the core. Source bursts and sink stalls vary
// throughout the run. Every result is checked against an in-bench date model.
// ----------------------------------------------------------------------------
module tb;
	import mjdtd_pkg::*;

	localparam int LATENCY         = 9;
	localparam int RANDOM_REQUESTS = 1950;
	localparam int QUIET_LIMIT     = 4000;
	localparam int REPORT_LIMIT    = 10;

	// Lengths of the leap day's last minute that raise a warning
	localparam logic [LEN_W-1:0] MINUTE_INSERTED = 6'd61;
	localparam logic [LEN_W-1:0] MINUTE_DELETED  = 6'd59;

	// Days elapsed before the first of each month, common year
	localparam int DAYS_BEFORE_MONTH [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	typedef enum int {
		SINK_OPEN,
		SINK_TOGGLE,
		SINK_BUSY,
		SINK_CHOKED
	} sink_mode_t;

	// ------------------------------------------------------------------------
	// Date ledger: holds the dates due from the core, oldest first
	// ------------------------------------------------------------------------
	class date_ledger;
		res_t        dates_due[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Fliegel-Van Flandern: day number to year, month and day
		function void civil_date(input logic [MJD_W-1:0] mjd, output longint yr,
				output longint mo, output longint dy);
			longint a, cent, yq, mq, k;
			a    = longint'(mjd) + 2468570;
			cent = (4 * a) / 146097;
			a    = a - (146097 * cent + 3) / 4;
			yq   = (4000 * (a + 1)) / 1461001;
			a    = a - (1461 * yq) / 4 + 31;
			mq   = (80 * a) / 2447;
			dy   = a - (2447 * mq) / 80;
			k    = mq / 11;
			mo   = mq + 2 - 12 * k;
			yr   = 100 * (cent - 49) + yq + k;
		endfunction

		function bit is_leap_year(longint yr);
			if (yr % 4 != 0) begin
				return 1'b0;
			end
			if (yr % 100 != 0) begin
				return 1'b1;
			end
			return (yr % 400) == 0;
		endfunction

		function res_t date_for(req_t r);
			res_t   d;
			longint yr, mo, dy, lyr, lmo, ldy, doy;
			longint midx;
			civil_date(r.mjd_day, yr, mo, dy);
			midx = (mo - 1) & 15;
			if (midx > 11) begin
				midx = 11;
			end
			doy = dy + DAYS_BEFORE_MONTH[midx];
			if (is_leap_year(yr) && mo > 2) begin
				doy++;
			end
			d             = '0;
			d.cal_year    = YEAR_W'(yr);
			d.cal_month   = MON_W'(mo);
			d.cal_day     = DAY_W'(dy);
			d.day_of_year = DOY_W'(doy);
			d.leap_code   = LEAP_NONE;
			// Only year and month are compared: a leap day earlier in the month still matches
			if (r.leap_pending) begin
				civil_date(r.leap_mjd, lyr, lmo, ldy);
				if (lmo == mo && lyr == yr) begin
					if (r.last_minute_len == MINUTE_INSERTED) begin
						d.leap_code = LEAP_INSERT;
					end else if (r.last_minute_len == MINUTE_DELETED) begin
						d.leap_code = LEAP_DELETE;
					end
				end
			end
			return d;
		endfunction

		function void note_request(req_t r);
			dates_due.push_back(date_for(r));
		endfunction

		function void flag(string what, res_t want, res_t got);
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("mismatch (%s) at %0t: expected y=%0d m=%0d d=%0d doy=%0d code=%0d,",
					what, $realtime, want.cal_year, want.cal_month, want.cal_day,
					want.day_of_year, want.leap_code);
				$display("  got y=%0d m=%0d d=%0d doy=%0d code=%0d", got.cal_year,
					got.cal_month, got.cal_day, got.day_of_year, got.leap_code);
			end
		endfunction

		function void check_result(res_t got);
			res_t  want;
			string bad;
			if (dates_due.size() == 0) begin
				flag("result with no request outstanding", '0, got);
				return;
			end
			want = dates_due.pop_front();
			bad  = "";
			if (got.cal_year !== want.cal_year) begin
				bad = {bad, " cal_year"};
			end
			if (got.cal_month !== want.cal_month) begin
				bad = {bad, " cal_month"};
			end
			if (got.cal_day !== want.cal_day) begin
				bad = {bad, " cal_day"};
			end
			if (got.day_of_year !== want.day_of_year) begin
				bad = {bad, " day_of_year"};
			end
			if (got.leap_code !== want.leap_code) begin
				bad = {bad, " leap_code"};
			end
			if (bad != "") begin
				flag({"field", bad}, want, got);
			end
		endfunction

		function int outstanding();
			return dates_due.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	date_ledger ledger = new();

	mjd_to_date_leap_classifier_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both handshakes at the rising edge; inputs only move on the falling edge
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ledger.note_request(req_t'(s_tdata));
		end
		if (m_tvalid && m_tready) begin
			ledger.check_result(res_t'(m_tdata));
		end
	end

	// Watchdog: end the run when no handshake completes for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	// Result sink: switch between stall patterns in runs of random length
	initial begin : sink
		sink_mode_t  mode;
		int unsigned run;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = sink_mode_t'($urandom_range(SINK_CHOKED, SINK_OPEN));
			run  = $urandom_range(60, 1);
			repeat (run) begin
				@(negedge clk);
				case (mode)
					SINK_OPEN:   m_tready <= 1'b1;
					SINK_TOGGLE: m_tready <= ~m_tready;
					SINK_BUSY:   m_tready <= ($urandom_range(3) != 0);
					default:     m_tready <= ($urandom_range(7) == 0);
				endcase
			end
		end
	end

	function automatic req_t make_req(input logic [MJD_W-1:0] mjd, input logic pend,
			input logic [MJD_W-1:0] lmjd, input logic [LEN_W-1:0] len);
		req_t r;
		r                 = '0;
		r.mjd_day         = mjd;
		r.leap_pending    = pend;
		r.leap_mjd        = lmjd;
		r.last_minute_len = len;
		return r;
	endfunction

	// Mostly leap reports near the current date so year/month matches are common
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		r         = '0;
		pick      = $urandom_range(19);
		r.mjd_day = (pick == 0) ? '0 : (pick == 1) ? '1 : MJD_W'($urandom_range(20'hFFFFF));
		r.leap_pending = ($urandom_range(4) != 0);
		pick = $urandom_range(9);
		if (pick < 6) begin
			r.leap_mjd = r.mjd_day - 20'd40 + MJD_W'($urandom_range(80));
		end else if (pick == 6) begin
			r.leap_mjd = r.mjd_day;
		end else begin
			r.leap_mjd = MJD_W'($urandom_range(20'hFFFFF));
		end
		pick = $urandom_range(9);
		if (pick < 4) begin
			r.last_minute_len = MINUTE_INSERTED;
		end else if (pick < 8) begin
			r.last_minute_len = MINUTE_DELETED;
		end else if (pick == 8) begin
			r.last_minute_len = 6'd60;
		end else begin
			r.last_minute_len = LEN_W'($urandom_range(63));
		end
		return r;
	endfunction

	// Present one request and hold it until accepted; starts and ends on a falling edge
	task automatic push_request(input req_t r);
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid for the requested idle stretch and put junk on the data bus meanwhile
	task automatic hold_off(input int unsigned cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_TDATA_W'({$urandom, $urandom});
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Stop sending until every outstanding date has come back
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (ledger.outstanding() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_calendar_corners();
		push_request(make_req(20'd0, 1'b0, 20'd0, 6'd0));
		push_request(make_req(20'hFFFFF, 1'b1, 20'hFFFFF, 6'd63));
		push_request(make_req(20'hFFFFF, 1'b1, 20'hFFFFF, MINUTE_INSERTED));
		push_request(make_req(20'd0, 1'b1, 20'd0, MINUTE_DELETED));
		// No leap pending: leap fields are ignored even when they would match
		push_request(make_req(20'd51603, 1'b0, 20'd51603, MINUTE_INSERTED));
		push_request(make_req(20'd51602, 1'b1, 20'd51590, MINUTE_DELETED));
		push_request(make_req(20'd51604, 1'b1, 20'd51620, MINUTE_INSERTED));
		// Last day of a leap year, leap day earlier in the month
		push_request(make_req(20'd51909, 1'b1, 20'd51880, MINUTE_DELETED));
		push_request(make_req(20'd51910, 1'b1, 20'd51909, MINUTE_INSERTED));
		// Century years: 1900 and 2100 are common years, 2000 is leap
		push_request(make_req(20'd15079, 1'b1, 20'd15079, MINUTE_DELETED));
		push_request(make_req(20'd88128, 1'b1, 20'd88128, MINUTE_INSERTED));
		push_request(make_req(20'd57753, 1'b1, 20'd57753, MINUTE_INSERTED));
		push_request(make_req(20'd57754, 1'b1, 20'd57753, MINUTE_INSERTED));
		// Same year, other month: no warning
		push_request(make_req(20'd57388, 1'b1, 20'd57753, MINUTE_INSERTED));
		// Other minute lengths: no warning
		push_request(make_req(20'd57753, 1'b1, 20'd57753, 6'd60));
		push_request(make_req(20'd57753, 1'b1, 20'd57753, 6'd0));
		push_request(make_req(20'h55555, 1'b1, 20'hAAAAA, 6'h2A));
		push_request(make_req(20'hAAAAA, 1'b1, 20'h55555, 6'h15));
		push_request(make_req(20'd51544, 1'b1, 20'd51574, MINUTE_INSERTED));
		push_request(make_req(20'd51574, 1'b1, 20'd51575, MINUTE_DELETED));
		// Same month and day of month, other year
		push_request(make_req(20'd51544, 1'b1, 20'd51910, MINUTE_DELETED));
	endtask

	initial begin : source
		int unsigned burst;
		int unsigned n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_calendar_corners();
		drain_pipeline();

		// Random requests in bursts; idle stretches are sometimes empty
		burst = 0;
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 2) begin
				drain_pipeline();
			end
			if (burst == 0) begin
				burst = $urandom_range(40, 1);
				hold_off(($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1));
			end
			push_request(random_request());
			burst--;
		end

		drain_pipeline();
		repeat (3 * LATENCY) @(negedge clk);
		if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
